// ===== hw/rtl/lprd_pkg.sv =====
// Package for the length-prefixed request deframer.
// Holds field widths, default limits and the verdict error codes.
// No dependencies.
package lprd_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 4096;
  localparam int unsigned MAX_ARGS_DEF        = 4096 / 4;

  localparam int unsigned FRAME_LEN_W = 13;
  localparam int unsigned ARG_CNT_W   = 11;
  localparam int unsigned ARG_IDX_W   = 10;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned BODY_MIN    = 4;

  localparam logic [FRAME_LEN_W-1:0] MAX_FRAME_LEN_RST = 13'd4096;
  localparam logic [ARG_CNT_W-1:0]   MAX_ARG_COUNT_RST = 11'd1024;

  typedef enum logic {
    CFG_MAX_FRAME_LEN = 1'b0,
    CFG_MAX_ARG_COUNT = 1'b1
  } lprd_cfg_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_LEN_LIMIT  = 3'd1,
    ERR_BODY_SHORT = 3'd2,
    ERR_ARG_LIMIT  = 3'd3,
    ERR_OVERRUN    = 3'd4,
    ERR_TRAILING   = 3'd5
  } lprd_err_t;

endpackage

// ===== hw/rtl/length_prefixed_request_deframer.sv =====
// Length-prefixed request deframer: top-level design module.
// Depends on lprd_pkg for widths, reset limits and error codes.
//
//  channel | direction | tdata                                    | tuser / tlast
//  s_*     | in        | [7:0] stream_byte                        | tuser[0] new_connection
//  m_*     | out       | [7:0] data_byte, [17:8] arg_index,       | tuser[0] has_byte,
//          |           | [18] frame_ok, [21:19] error_code,       | tuser[1] frame_done,
//          |           | [32:22] arg_count, [39:33] zero          | tlast arg_last
//  cfg_*   | in        | cfg_index selects the limit, cfg_data    | none
//
// Each byte is parsed combinationally, and its result, if any, appears in the
// output register on the next cycle. One byte is accepted per unstalled cycle.
// The input stalls only while the output register holds a result not yet taken.
// Synchronous reset clears the parser, the halt flag and the output valid flag,
// and restores the limits to their reset values.
module length_prefixed_request_deframer #(
  parameter int unsigned MAX_FRAME_BYTES = lprd_pkg::MAX_FRAME_BYTES_DEF,
  parameter int unsigned MAX_ARGS        = lprd_pkg::MAX_ARGS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] stream_byte
  input  logic [0:0]  s_tuser,   // [0] new_connection
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // data_byte, arg_index, frame_ok, error_code, arg_count
  output logic [1:0]  m_tuser,   // [0] has_byte, [1] frame_done
  output logic        m_tlast,   // arg_last
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [lprd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned FLW = lprd_pkg::FRAME_LEN_W;
  localparam int unsigned ACW = lprd_pkg::ARG_CNT_W;
  localparam int unsigned AIW = lprd_pkg::ARG_IDX_W;

  typedef enum logic [1:0] {
    PH_LEN   = 2'd0,
    PH_COUNT = 2'd1,
    PH_SIZE  = 2'd2,
    PH_DATA  = 2'd3
  } phase_t;

  logic [FLW-1:0] max_frame_len;
  logic [ACW-1:0] max_arg_count;

  phase_t         parse_phase, parse_phase_next;
  logic [23:0]    field_shift, field_shift_next;
  logic [1:0]     field_byte_count, field_byte_count_next;
  logic [FLW-1:0] frame_length, frame_length_next;
  logic [FLW-1:0] body_position, body_position_next;
  logic [ACW-1:0] args_left, args_left_next;
  logic [ACW-1:0] arg_number, arg_number_next;
  logic [FLW-1:0] arg_bytes_left, arg_bytes_left_next;
  logic [ACW-1:0] arg_total, arg_total_next;
  logic           halted, halted_next;

  phase_t         cur_phase;
  logic [23:0]    cur_shift;
  logic [1:0]     cur_count;
  logic [FLW-1:0] cur_flen;
  logic [FLW-1:0] cur_bpos;
  logic [ACW-1:0] cur_args_left;
  logic [ACW-1:0] cur_argn;
  logic [FLW-1:0] cur_abl;
  logic [ACW-1:0] cur_atot;
  logic           cur_halted;

  logic [7:0]     in_byte;
  logic           in_new_conn;
  logic           s_accept;
  logic [31:0]    flim, alim;
  logic [31:0]    field_value;
  logic           field_done;
  logic [FLW-1:0] bpos_inc;
  logic [FLW-1:0] abl_dec;

  logic           go_next;
  logic [ACW-1:0] next_args;
  logic           vd, vok;
  lprd_pkg::lprd_err_t vcode;
  logic           emit;
  logic           r_has_byte, r_arg_last;
  logic [7:0]     r_data;
  logic [AIW-1:0] r_index;
  logic [ACW-1:0] arg_total_next_at_verdict;

  assign in_byte     = s_tdata[7:0];
  assign in_new_conn = s_tuser[0];
  assign s_tready    = !m_tvalid || m_tready;
  assign s_accept    = s_tvalid && s_tready;

  assign flim = (32'(max_frame_len) < 32'(MAX_FRAME_BYTES)) ? 32'(max_frame_len)
                                                            : 32'(MAX_FRAME_BYTES);
  assign alim = (32'(max_arg_count) < 32'(MAX_ARGS)) ? 32'(max_arg_count)
                                                     : 32'(MAX_ARGS);

  always_comb begin
    cur_phase     = in_new_conn ? PH_LEN : parse_phase;
    cur_shift     = in_new_conn ? '0 : field_shift;
    cur_count     = in_new_conn ? '0 : field_byte_count;
    cur_flen      = in_new_conn ? '0 : frame_length;
    cur_bpos      = in_new_conn ? '0 : body_position;
    cur_args_left = in_new_conn ? '0 : args_left;
    cur_argn      = in_new_conn ? '0 : arg_number;
    cur_abl       = in_new_conn ? '0 : arg_bytes_left;
    cur_atot      = in_new_conn ? '0 : arg_total;
    cur_halted    = in_new_conn ? 1'b0 : halted;
  end

  assign field_done  = (cur_count == 2'd3);
  assign field_value = {in_byte, cur_shift};
  assign bpos_inc    = cur_bpos + FLW'(1);
  assign abl_dec     = (cur_abl != '0) ? cur_abl - FLW'(1) : cur_abl;

  always_comb begin
    parse_phase_next      = cur_phase;
    field_shift_next      = cur_shift;
    field_byte_count_next = cur_count;
    frame_length_next     = cur_flen;
    body_position_next    = cur_bpos;
    args_left_next        = cur_args_left;
    arg_number_next       = cur_argn;
    arg_bytes_left_next   = cur_abl;
    arg_total_next        = cur_atot;
    halted_next           = cur_halted;
    go_next    = 1'b0;
    next_args  = cur_args_left;
    vd         = 1'b0;
    vok        = 1'b0;
    vcode      = lprd_pkg::ERR_NONE;
    emit       = 1'b0;
    r_has_byte = 1'b0;
    r_arg_last = 1'b0;
    r_data     = '0;
    r_index    = '0;

    if (!cur_halted) begin
      if (cur_phase != PH_LEN) begin
        body_position_next = bpos_inc;
      end
      if (cur_phase != PH_DATA) begin
        if (field_done) begin
          field_shift_next      = '0;
          field_byte_count_next = '0;
        end else begin
          field_shift_next      = cur_shift | (24'(in_byte) << {cur_count, 3'b000});
          field_byte_count_next = cur_count + 2'd1;
        end
      end

      case (cur_phase)
        PH_LEN: begin
          if (field_done) begin
            if (field_value > flim) begin
              vd    = 1'b1;
              vcode = lprd_pkg::ERR_LEN_LIMIT;
            end else if (field_value < 32'(lprd_pkg::BODY_MIN)) begin
              vd    = 1'b1;
              vcode = lprd_pkg::ERR_BODY_SHORT;
            end else begin
              frame_length_next  = field_value[FLW-1:0];
              body_position_next = '0;
              parse_phase_next   = PH_COUNT;
            end
          end
        end
        PH_COUNT: begin
          if (field_done) begin
            arg_total_next = (field_value > 32'd2047) ? '1 : field_value[ACW-1:0];
            if (field_value > alim) begin
              vd    = 1'b1;
              vcode = lprd_pkg::ERR_ARG_LIMIT;
            end else begin
              args_left_next  = field_value[ACW-1:0];
              arg_number_next = '0;
              next_args       = field_value[ACW-1:0];
              go_next         = 1'b1;
            end
          end
        end
        PH_SIZE: begin
          if (field_done) begin
            if (33'(bpos_inc) + 33'(field_value) > 33'(cur_flen)) begin
              vd    = 1'b1;
              vcode = lprd_pkg::ERR_OVERRUN;
            end else if (field_value == 32'd0) begin
              emit            = 1'b1;
              r_arg_last      = 1'b1;
              r_index         = cur_argn[AIW-1:0];
              next_args       = cur_args_left - ACW'(1);
              args_left_next  = next_args;
              arg_number_next = cur_argn + ACW'(1);
              go_next         = 1'b1;
            end else begin
              arg_bytes_left_next = field_value[FLW-1:0];
              parse_phase_next    = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          emit                = 1'b1;
          r_has_byte          = 1'b1;
          r_data              = in_byte;
          r_index             = cur_argn[AIW-1:0];
          arg_bytes_left_next = abl_dec;
          if (abl_dec == '0) begin
            r_arg_last      = 1'b1;
            next_args       = cur_args_left - ACW'(1);
            args_left_next  = next_args;
            arg_number_next = cur_argn + ACW'(1);
            go_next         = 1'b1;
          end
        end
        default: begin
          parse_phase_next = PH_LEN;
        end
      endcase

      if (go_next) begin
        if (next_args == '0) begin
          vd    = 1'b1;
          vok   = (bpos_inc == cur_flen);
          vcode = vok ? lprd_pkg::ERR_NONE : lprd_pkg::ERR_TRAILING;
        end else if ((FLW+1)'(bpos_inc) + (FLW+1)'(4) > (FLW+1)'(cur_flen)) begin
          vd    = 1'b1;
          vcode = lprd_pkg::ERR_OVERRUN;
        end else begin
          parse_phase_next = PH_SIZE;
        end
      end

      if (vd) begin
        emit                  = 1'b1;
        parse_phase_next      = PH_LEN;
        field_shift_next      = '0;
        field_byte_count_next = '0;
        frame_length_next     = '0;
        body_position_next    = '0;
        args_left_next        = '0;
        arg_number_next       = '0;
        arg_bytes_left_next   = '0;
        arg_total_next        = '0;
        halted_next           = !vok;
      end
    end
  end

  // Count reported with a verdict: the value held after the count field,
  // or the freshly decoded one when the verdict comes on that field.
  assign arg_total_next_at_verdict =
    (cur_phase == PH_COUNT && field_done)
      ? ((field_value > 32'd2047) ? '1 : field_value[ACW-1:0])
      : cur_atot;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len    <= lprd_pkg::MAX_FRAME_LEN_RST;
      max_arg_count    <= lprd_pkg::MAX_ARG_COUNT_RST;
      parse_phase      <= PH_LEN;
      field_shift      <= '0;
      field_byte_count <= '0;
      frame_length     <= '0;
      body_position    <= '0;
      args_left        <= '0;
      arg_number       <= '0;
      arg_bytes_left   <= '0;
      arg_total        <= '0;
      halted           <= 1'b0;
      m_tvalid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lprd_pkg::CFG_MAX_FRAME_LEN: max_frame_len <= cfg_data[FLW-1:0];
          lprd_pkg::CFG_MAX_ARG_COUNT: max_arg_count <= cfg_data[ACW-1:0];
          default: ;
        endcase
      end
      if (s_accept) begin
        parse_phase      <= parse_phase_next;
        field_shift      <= field_shift_next;
        field_byte_count <= field_byte_count_next;
        frame_length     <= frame_length_next;
        body_position    <= body_position_next;
        args_left        <= args_left_next;
        arg_number       <= arg_number_next;
        arg_bytes_left   <= arg_bytes_left_next;
        arg_total        <= arg_total_next;
        halted           <= halted_next;
        m_tvalid         <= emit;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept && emit) begin
      m_tdata <= {7'd0,
                  vd ? arg_total_next_at_verdict : ACW'(0),
                  vcode,
                  vok,
                  r_index,
                  r_data};
      m_tuser <= {vd, r_has_byte};
      m_tlast <= r_arg_last;
    end
  end

endmodule

// ===== hw/rtl/lprd_checker.sv =====
// Port-level checker for the length-prefixed request deframer.
// Depends on lprd_pkg for error codes; bound to the top level below.
module lprd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // A stalled result holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // Verdict fields are zero on results that carry no verdict.
  a_no_verdict: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> m_tdata[39:18] == 22'd0)
    else $error("verdict fields set without frame_done");

  // An accepted frame carries no error code.
  a_ok_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] && m_tdata[18] |-> m_tdata[21:19] == lprd_pkg::ERR_NONE)
    else $error("accepted frame with error code");

  // A rejected frame carries a defined error code.
  a_reject_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] && !m_tdata[18] |->
      m_tdata[21:19] != lprd_pkg::ERR_NONE && m_tdata[21:19] <= lprd_pkg::ERR_TRAILING)
    else $error("rejected frame without valid error code");

  // A result without data is either an empty argument or a verdict.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'd0 && (m_tlast || m_tuser[1]))
    else $error("result without data, marker or verdict");

endmodule

bind length_prefixed_request_deframer lprd_checker u_lprd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
